// ===== rtl/core/vidl_pkg.sv =====
package vidl_pkg;

    localparam int DEF_STORE_DEPTH = 32768;
    localparam int DEF_FRAC_BITS   = 16;
    localparam int DEF_SAMPLE_BITS = 24;

    localparam int LEN_CFG_W  = 16;
    localparam int SPD_W      = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int MIN_LENGTH = 8;
    localparam int PC_W       = 5;

    localparam logic [CFG_IDX_W-1:0] REG_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SPEED  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = CFG_IDX_W'(2);

    localparam logic [LEN_CFG_W-1:0] RESET_LENGTH = 16'd32768;
    localparam logic [SPD_W-1:0]     RESET_SPEED  = 20'd65536;
    localparam logic                 MODE_LINEAR  = 1'b0;

    typedef struct packed {
        logic [LEN_CFG_W-1:0]    buffer_length;
        logic signed [SPD_W-1:0] read_speed;
        logic                    interp_mode;
    } cfg_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_CLEAR,
        OP_WAIT_IN,
        OP_LOAD_RPR,
        OP_DIV_RP,
        OP_TAKE_RPR,
        OP_RD_M1,
        OP_RD_0,
        OP_RD_P1,
        OP_RD_P2,
        OP_CAP_P2,
        OP_H_DIFF,
        OP_H_W,
        OP_H_A,
        OP_H_B,
        OP_MUL,
        OP_H_P1,
        OP_H_P2,
        OP_H_P3,
        OP_H_Y,
        OP_L_D,
        OP_L_Y,
        OP_OUT,
        OP_R_SUM,
        OP_R_ADJ,
        OP_R_FIX,
        OP_DIV_R,
        OP_TAKE_R
    } op_t;

    typedef enum logic [3:0] {
        COND_NEXT,
        COND_JUMP,
        COND_CLR_BUSY,
        COND_NO_BEAT,
        COND_RP_OK,
        COND_DIV_BUSY,
        COND_LINEAR,
        COND_OUT_FULL,
        COND_R_FAST
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic clr_busy;
        logic in_beat;
        logic rp_ok;
        logic div_busy;
        logic linear;
        logic out_full;
        logic r_fast;
    } stat_t;

    localparam logic [PC_W-1:0] STEP_CLEAR       = PC_W'(0);
    localparam logic [PC_W-1:0] STEP_WAIT        = PC_W'(1);
    localparam logic [PC_W-1:0] STEP_DIV_RP_WAIT = PC_W'(4);
    localparam logic [PC_W-1:0] STEP_TAPS        = PC_W'(6);
    localparam logic [PC_W-1:0] STEP_LINEAR      = PC_W'(22);
    localparam logic [PC_W-1:0] STEP_OUT         = PC_W'(25);
    localparam logic [PC_W-1:0] STEP_DIV_R_WAIT  = PC_W'(30);

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t uc;
        uc = '{OP_NOP, COND_NEXT, STEP_CLEAR};
        case (pc)
            PC_W'(0):  uc = '{OP_CLEAR,    COND_CLR_BUSY, STEP_CLEAR};
            PC_W'(1):  uc = '{OP_WAIT_IN,  COND_NO_BEAT,  STEP_WAIT};
            PC_W'(2):  uc = '{OP_LOAD_RPR, COND_RP_OK,    STEP_TAPS};
            PC_W'(3):  uc = '{OP_DIV_RP,   COND_NEXT,     STEP_CLEAR};
            PC_W'(4):  uc = '{OP_NOP,      COND_DIV_BUSY, STEP_DIV_RP_WAIT};
            PC_W'(5):  uc = '{OP_TAKE_RPR, COND_NEXT,     STEP_CLEAR};
            PC_W'(6):  uc = '{OP_RD_M1,    COND_NEXT,     STEP_CLEAR};
            PC_W'(7):  uc = '{OP_RD_0,     COND_NEXT,     STEP_CLEAR};
            PC_W'(8):  uc = '{OP_RD_P1,    COND_NEXT,     STEP_CLEAR};
            PC_W'(9):  uc = '{OP_RD_P2,    COND_NEXT,     STEP_CLEAR};
            PC_W'(10): uc = '{OP_CAP_P2,   COND_LINEAR,   STEP_LINEAR};
            PC_W'(11): uc = '{OP_H_DIFF,   COND_NEXT,     STEP_CLEAR};
            PC_W'(12): uc = '{OP_H_W,      COND_NEXT,     STEP_CLEAR};
            PC_W'(13): uc = '{OP_H_A,      COND_NEXT,     STEP_CLEAR};
            PC_W'(14): uc = '{OP_H_B,      COND_NEXT,     STEP_CLEAR};
            PC_W'(15): uc = '{OP_MUL,      COND_NEXT,     STEP_CLEAR};
            PC_W'(16): uc = '{OP_H_P1,     COND_NEXT,     STEP_CLEAR};
            PC_W'(17): uc = '{OP_MUL,      COND_NEXT,     STEP_CLEAR};
            PC_W'(18): uc = '{OP_H_P2,     COND_NEXT,     STEP_CLEAR};
            PC_W'(19): uc = '{OP_MUL,      COND_NEXT,     STEP_CLEAR};
            PC_W'(20): uc = '{OP_H_P3,     COND_NEXT,     STEP_CLEAR};
            PC_W'(21): uc = '{OP_H_Y,      COND_JUMP,     STEP_OUT};
            PC_W'(22): uc = '{OP_L_D,      COND_NEXT,     STEP_CLEAR};
            PC_W'(23): uc = '{OP_MUL,      COND_NEXT,     STEP_CLEAR};
            PC_W'(24): uc = '{OP_L_Y,      COND_NEXT,     STEP_CLEAR};
            PC_W'(25): uc = '{OP_OUT,      COND_OUT_FULL, STEP_OUT};
            PC_W'(26): uc = '{OP_R_SUM,    COND_NEXT,     STEP_CLEAR};
            PC_W'(27): uc = '{OP_R_ADJ,    COND_NEXT,     STEP_CLEAR};
            PC_W'(28): uc = '{OP_R_FIX,    COND_R_FAST,   STEP_WAIT};
            PC_W'(29): uc = '{OP_DIV_R,    COND_NEXT,     STEP_CLEAR};
            PC_W'(30): uc = '{OP_NOP,      COND_DIV_BUSY, STEP_DIV_R_WAIT};
            PC_W'(31): uc = '{OP_TAKE_R,   COND_JUMP,     STEP_WAIT};
            default:   uc = '{OP_NOP,      COND_NEXT,     STEP_CLEAR};
        endcase
        return uc;
    endfunction

endpackage

// ===== rtl/core/vidl_rem.sv =====
module vidl_rem #(
    parameter int DIV_W = 32,
    parameter int M_W   = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [M_W-1:0]   divisor,
    output logic             busy,
    output logic [M_W-1:0]   rem
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [DIV_W-1:0] quo_reg;
    logic [M_W-1:0]   rem_reg;
    logic [M_W:0]     trial;
    logic [M_W:0]     diff;
    logic             ge;

    // restoring remainder, one dividend bit per cycle
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign ge    = trial >= {1'b0, divisor};

    always_comb
    begin
        cnt_next = cnt_reg;
        if (start)
        begin
            cnt_next = CNT_W'(DIV_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            rem_reg <= ge ? diff[M_W-1:0] : trial[M_W-1:0];
        end
    end

    assign busy = cnt_reg != '0;
    assign rem  = rem_reg;

endmodule

// ===== rtl/core/vidl_seq.sv =====
module vidl_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  vidl_pkg::stat_t stat,
    output vidl_pkg::op_t   op
);

    logic [vidl_pkg::PC_W-1:0] pc_reg;
    logic [vidl_pkg::PC_W-1:0] pc_next;
    vidl_pkg::ucode_t          uc;
    logic                      take;

    assign uc = vidl_pkg::ucode_rom(pc_reg);
    assign op = uc.op;

    always_comb
    begin
        unique case (uc.cond)
            vidl_pkg::COND_NEXT:     take = 1'b0;
            vidl_pkg::COND_JUMP:     take = 1'b1;
            vidl_pkg::COND_CLR_BUSY: take = stat.clr_busy;
            vidl_pkg::COND_NO_BEAT:  take = !stat.in_beat;
            vidl_pkg::COND_RP_OK:    take = stat.rp_ok;
            vidl_pkg::COND_DIV_BUSY: take = stat.div_busy;
            vidl_pkg::COND_LINEAR:   take = stat.linear;
            vidl_pkg::COND_OUT_FULL: take = stat.out_full;
            vidl_pkg::COND_R_FAST:   take = stat.r_fast;
            default:                 take = 1'b0;
        endcase
        pc_next = take ? uc.target : pc_reg + vidl_pkg::PC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= vidl_pkg::STEP_CLEAR;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== rtl/core/vidl_dp.sv =====
module vidl_dp #(
    parameter int STORE_DEPTH = vidl_pkg::DEF_STORE_DEPTH,
    parameter int FRAC_BITS   = vidl_pkg::DEF_FRAC_BITS,
    parameter int SAMPLE_BITS = vidl_pkg::DEF_SAMPLE_BITS,
    parameter int DIV_W       = 32,
    parameter int M_W         = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  vidl_pkg::op_t          op,
    input  vidl_pkg::cfg_t         cfg,
    input  logic                   s_tvalid,
    input  logic [SAMPLE_BITS-1:0] s_data,
    output logic                   s_tready,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output logic [SAMPLE_BITS-1:0] m_data,
    output vidl_pkg::stat_t        stat,
    output logic                   div_start,
    output logic [DIV_W-1:0]       div_dividend,
    output logic [M_W-1:0]         div_divisor,
    input  logic                   div_busy,
    input  logic [M_W-1:0]         div_rem
);

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int LEN_W  = ADDR_W + 1;
    localparam int RP_W   = ADDR_W + FRAC_BITS;
    localparam int MAXW   = (RP_W > vidl_pkg::SPD_W) ? RP_W : vidl_pkg::SPD_W;
    localparam int R_W    = MAXW + 3;
    localparam int CMP_W  = (LEN_W > vidl_pkg::LEN_CFG_W) ? LEN_W : vidl_pkg::LEN_CFG_W;
    localparam int AW     = SAMPLE_BITS + 6;
    localparam int PW     = AW + FRAC_BITS + 1;
    localparam int S      = SAMPLE_BITS;

    logic [S-1:0]      mem [STORE_DEPTH];
    logic [S-1:0]      rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [S-1:0]      mem_wd;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_ra;

    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [ADDR_W-1:0] clr_cnt_next;
    logic [ADDR_W-1:0] wp_reg;
    logic [ADDR_W-1:0] wp_next;
    logic [RP_W-1:0]   rp_reg;
    logic [RP_W-1:0]   rp_next;
    logic [RP_W-1:0]   rpr_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [S-1:0]      out_data_reg;

    logic signed [S-1:0]    xm1_reg, x0_reg, x1_reg, x2_reg;
    logic signed [AW-1:0]   c2_reg, v_reg, d_reg, w2_reg, b2_reg, acc_reg;
    logic signed [PW-1:0]   prod_reg;
    logic signed [R_W-1:0]  r_reg, adj_reg;

    logic [CMP_W-1:0]       blx, len_c;
    logic [LEN_W-1:0]       len_use;
    logic [M_W-1:0]         m_len;
    logic signed [R_W-1:0]  m_s;
    logic [ADDR_W-1:0]      t_idx;
    logic [LEN_W-1:0]       tl, s1, s2, wp1;
    logic [ADDR_W-1:0]      idx_m1, idx_0, idx_p1, idx_p2;
    logic signed [FRAC_BITS:0] f_s;
    logic signed [AW-1:0]   prod_sh;
    logic signed [R_W-1:0]  r_sum, r_mag;
    logic                   r_neg, adj_neg, r_in, adj_in;
    logic                   sat_fits;
    logic [S-1:0]           sat_val;

    // length in use, clamped
    assign blx     = CMP_W'(cfg.buffer_length);
    assign len_c   = (blx < CMP_W'(vidl_pkg::MIN_LENGTH)) ? CMP_W'(vidl_pkg::MIN_LENGTH) :
                     (blx > CMP_W'(STORE_DEPTH)) ? CMP_W'(STORE_DEPTH) : blx;
    assign len_use = len_c[LEN_W-1:0];
    assign m_len   = {len_use, {FRAC_BITS{1'b0}}};
    assign m_s     = R_W'(m_len);

    // tap indexes around the reduced pointer
    assign t_idx  = rpr_reg[RP_W-1:FRAC_BITS];
    assign tl     = {1'b0, t_idx};
    assign s1     = tl + LEN_W'(1);
    assign s2     = tl + LEN_W'(2);
    assign idx_0  = t_idx;

    always_comb
    begin
        idx_m1 = (t_idx == '0) ? ADDR_W'(len_use - LEN_W'(1)) : ADDR_W'(tl - LEN_W'(1));
        idx_p1 = (s1 >= len_use) ? ADDR_W'(s1 - len_use) : ADDR_W'(s1);
        idx_p2 = (s2 >= len_use) ? ADDR_W'(s2 - len_use) : ADDR_W'(s2);
    end

    assign f_s     = $signed({1'b0, rpr_reg[FRAC_BITS-1:0]});
    assign prod_sh = AW'(prod_reg >>> FRAC_BITS);

    assign r_sum   = $signed(R_W'(rpr_reg)) + R_W'(cfg.read_speed);
    assign r_neg   = r_reg[R_W-1];
    assign adj_neg = adj_reg[R_W-1];
    assign r_in    = !r_neg && (r_reg < m_s);
    assign adj_in  = !adj_neg && (adj_reg < m_s);
    assign r_mag   = r_neg ? -r_reg : r_reg;

    assign wp1     = {1'b0, wp_reg} + LEN_W'(1);

    assign sat_fits = (acc_reg[AW-1:S-1] == '0) || (acc_reg[AW-1:S-1] == '1);
    assign sat_val  = sat_fits ? acc_reg[S-1:0] :
                      (acc_reg[AW-1] ? {1'b1, {(S-1){1'b0}}} : {1'b0, {(S-1){1'b1}}});

    assign s_tready = op == vidl_pkg::OP_WAIT_IN;

    assign stat.clr_busy = clr_cnt_reg != ADDR_W'(STORE_DEPTH - 1);
    assign stat.in_beat  = s_tvalid && s_tready;
    assign stat.rp_ok    = M_W'(rp_reg) < m_len;
    assign stat.div_busy = div_busy;
    assign stat.linear   = cfg.interp_mode == vidl_pkg::MODE_LINEAR;
    assign stat.out_full = out_valid_reg && !m_tready;
    assign stat.r_fast   = r_in || adj_in;

    assign div_start    = (op == vidl_pkg::OP_DIV_RP) || (op == vidl_pkg::OP_DIV_R);
    assign div_dividend = (op == vidl_pkg::OP_DIV_R) ? DIV_W'(r_mag) : DIV_W'(rp_reg);
    assign div_divisor  = m_len;

    // store ports
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = wp_reg;
        mem_wd = s_data;
        mem_re = 1'b0;
        mem_ra = idx_0;
        unique case (op)
            vidl_pkg::OP_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = clr_cnt_reg;
                mem_wd = '0;
            end
            vidl_pkg::OP_WAIT_IN: mem_we = s_tvalid;
            vidl_pkg::OP_RD_M1:
            begin
                mem_re = 1'b1;
                mem_ra = idx_m1;
            end
            vidl_pkg::OP_RD_0:    mem_re = 1'b1;
            vidl_pkg::OP_RD_P1:
            begin
                mem_re = 1'b1;
                mem_ra = idx_p1;
            end
            vidl_pkg::OP_RD_P2:
            begin
                mem_re = 1'b1;
                mem_ra = idx_p2;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    // pointers, clear counter, output beat
    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (op)
            vidl_pkg::OP_CLEAR:
            begin
                if (stat.clr_busy)
                begin
                    clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                end
            end
            vidl_pkg::OP_OUT:
            begin
                if (!stat.out_full)
                begin
                    out_valid_next = 1'b1;
                end
            end
            vidl_pkg::OP_R_SUM:
            begin
                wp_next = (wp1 >= len_use) ? '0 : wp1[ADDR_W-1:0];
            end
            vidl_pkg::OP_R_FIX:
            begin
                if (r_in)
                begin
                    rp_next = r_reg[RP_W-1:0];
                end
                else if (adj_in)
                begin
                    rp_next = adj_reg[RP_W-1:0];
                end
            end
            vidl_pkg::OP_TAKE_R:
            begin
                if (!r_neg)
                begin
                    rp_next = div_rem[RP_W-1:0];
                end
                else if (div_rem == '0)
                begin
                    rp_next = '0;
                end
                else
                begin
                    rp_next = RP_W'(m_len - div_rem);
                end
            end
            default:
            begin
                rp_next = rp_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            wp_reg        <= '0;
            rp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // arithmetic steps
    always_ff @(posedge clk)
    begin
        unique case (op)
            vidl_pkg::OP_LOAD_RPR: rpr_reg <= rp_reg;
            vidl_pkg::OP_TAKE_RPR: rpr_reg <= div_rem[RP_W-1:0];
            vidl_pkg::OP_RD_0:     xm1_reg <= $signed(rd_data_reg);
            vidl_pkg::OP_RD_P1:    x0_reg  <= $signed(rd_data_reg);
            vidl_pkg::OP_RD_P2:    x1_reg  <= $signed(rd_data_reg);
            vidl_pkg::OP_CAP_P2:   x2_reg  <= $signed(rd_data_reg);
            vidl_pkg::OP_H_DIFF:
            begin
                c2_reg <= AW'(x1_reg) - AW'(xm1_reg);
                v_reg  <= AW'(x0_reg) - AW'(x1_reg);
                d_reg  <= AW'(x2_reg) - AW'(x0_reg);
            end
            vidl_pkg::OP_H_W:      w2_reg  <= c2_reg + (v_reg <<< 1);
            vidl_pkg::OP_H_A:      acc_reg <= w2_reg + (v_reg <<< 1) + d_reg;
            vidl_pkg::OP_H_B:      b2_reg  <= w2_reg + acc_reg;
            vidl_pkg::OP_MUL:      prod_reg <= PW'(acc_reg) * PW'(f_s);
            vidl_pkg::OP_H_P1:     acc_reg <= prod_sh - b2_reg;
            vidl_pkg::OP_H_P2:     acc_reg <= prod_sh + c2_reg;
            vidl_pkg::OP_H_P3:     acc_reg <= prod_sh;
            vidl_pkg::OP_H_Y:      acc_reg <= AW'(x0_reg) + (acc_reg >>> 1);
            vidl_pkg::OP_L_D:      acc_reg <= AW'(x1_reg) - AW'(x0_reg);
            vidl_pkg::OP_L_Y:      acc_reg <= AW'(x0_reg) + prod_sh;
            vidl_pkg::OP_OUT:
            begin
                if (!stat.out_full)
                begin
                    out_data_reg <= sat_val;
                end
            end
            vidl_pkg::OP_R_SUM:    r_reg   <= r_sum;
            vidl_pkg::OP_R_ADJ:    adj_reg <= r_neg ? r_reg + m_s : r_reg - m_s;
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_data   = out_data_reg;

endmodule

// ===== rtl/core/varispeed_interpolated_delay_line.sv =====
// Variable-speed delay line with fractional read position. Each input beat on s_axis is
// written into a circular sample store, then the store is read at the read pointer
// (FRAC_BITS fractional bits) with linear or four-point Hermite interpolation and one
// saturated sample leaves on m_axis. Write pointer steps by one, read pointer by
// read_speed, both wrapping at the clamped buffer_length (8 to STORE_DEPTH). After reset
// the store is zeroed, one entry per cycle, while s_axis_tready stays low. A sample then
// passes the microcode steps of linear or Hermite mode, one microcode step per cycle on a
// single store read port and one multiplier; the output step holds while m_axis_tready is
// low, and no new sample is taken until the last one's pointers are updated. When the
// read pointer lands more than one length outside the buffer (small FRAC_BITS, or a length
// shrunk below the pointer) a bit-serial remainder unit resolves the wrap. Write the
// configuration port only while no sample is in flight.
module varispeed_interpolated_delay_line #(
    parameter int STORE_DEPTH = vidl_pkg::DEF_STORE_DEPTH,
    parameter int FRAC_BITS   = vidl_pkg::DEF_FRAC_BITS,
    parameter int SAMPLE_BITS = vidl_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,   // sample_in
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_axis_tdata,   // sample_out
    input  logic                                 cfg_we,
    input  logic [vidl_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [vidl_pkg::SPD_W-1:0]           cfg_wdata
);

    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int RP_W    = ADDR_W + FRAC_BITS;
    localparam int M_W     = RP_W + 1;
    localparam int MAXW    = (RP_W > vidl_pkg::SPD_W) ? RP_W : vidl_pkg::SPD_W;
    localparam int DIV_W   = MAXW + 1;

    vidl_pkg::cfg_t  cfg_reg;
    vidl_pkg::cfg_t  cfg_next;
    vidl_pkg::op_t   op;
    vidl_pkg::stat_t stat;
    logic                   div_start;
    logic [DIV_W-1:0]       div_dividend;
    logic [M_W-1:0]         div_divisor;
    logic                   div_busy;
    logic [M_W-1:0]         div_rem;
    logic [SAMPLE_BITS-1:0] m_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                vidl_pkg::REG_LENGTH:
                    cfg_next.buffer_length = cfg_wdata[vidl_pkg::LEN_CFG_W-1:0];
                vidl_pkg::REG_SPEED:
                    cfg_next.read_speed = $signed(cfg_wdata);
                vidl_pkg::REG_MODE:
                    cfg_next.interp_mode = cfg_wdata[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.buffer_length <= vidl_pkg::RESET_LENGTH;
            cfg_reg.read_speed    <= $signed(vidl_pkg::RESET_SPEED);
            cfg_reg.interp_mode   <= vidl_pkg::MODE_LINEAR;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    vidl_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .op    (op)
    );

    vidl_dp #(
        .STORE_DEPTH (STORE_DEPTH),
        .FRAC_BITS   (FRAC_BITS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .DIV_W       (DIV_W),
        .M_W         (M_W)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .cfg          (cfg_reg),
        .s_tvalid     (s_axis_tvalid),
        .s_data       (s_axis_tdata[SAMPLE_BITS-1:0]),
        .s_tready     (s_axis_tready),
        .m_tready     (m_axis_tready),
        .m_tvalid     (m_axis_tvalid),
        .m_data       (m_data),
        .stat         (stat),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_busy     (div_busy),
        .div_rem      (div_rem)
    );

    vidl_rem #(
        .DIV_W (DIV_W),
        .M_W   (M_W)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .rem      (div_rem)
    );

    assign m_axis_tdata = TDATA_W'(m_data);

    a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("remainder unit restarted while busy");

    a_no_beat_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !stat.clr_busy)
        else $error("input taken before store clear finished");

    a_out_from_out_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(op == vidl_pkg::OP_OUT))
        else $error("output beat raised outside the output step");

endmodule

// ===== dv/vidl_output_check.sv =====
module vidl_output_check #(
    parameter int STORE_DEPTH = vidl_pkg::DEF_STORE_DEPTH,
    parameter int FRAC_BITS   = vidl_pkg::DEF_FRAC_BITS,
    parameter int SAMPLE_BITS = vidl_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     in_data,    // sample_in
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     out_data,   // sample_out
    input  logic                                 cfg_we,
    input  logic [vidl_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [vidl_pkg::SPD_W-1:0]           cfg_wdata,
    output int                                   samples_pending,
    output int                                   samples_checked,
    output int                                   mismatch_count
);

    localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;

    logic signed [SAMPLE_BITS-1:0]        sample_mem [STORE_DEPTH];
    longint                               wr_ptr;
    longint                               rd_ptr;
    logic [vidl_pkg::LEN_CFG_W-1:0]       cfg_length;
    logic signed [vidl_pkg::SPD_W-1:0]    cfg_speed;
    logic                                 cfg_mode;
    logic signed [SAMPLE_BITS-1:0]        expected_samples [$];
    logic signed [SAMPLE_BITS-1:0]        want;
    logic signed [SAMPLE_BITS-1:0]        got;
    int                                   n_checked;
    int                                   n_errors;

    function automatic longint tap_at(input longint base, input longint len, input int k);
        return longint'(sample_mem[(base % len + len + k) % len]);
    endfunction

    // store the new sample, read at the fractional position, then advance both pointers
    function automatic logic signed [SAMPLE_BITS-1:0] interpolate_next(
        input logic signed [SAMPLE_BITS-1:0] din
    );
        longint len, t, f, xm1, x0, x1, x2, c2, v, w2, a2, b2, p, y, span, r;
        len = longint'(cfg_length);
        if (len < vidl_pkg::MIN_LENGTH)
            len = vidl_pkg::MIN_LENGTH;
        if (len > STORE_DEPTH)
            len = STORE_DEPTH;
        t = rd_ptr >>> FRAC_BITS;
        f = rd_ptr & ((longint'(1) <<< FRAC_BITS) - 1);
        sample_mem[wr_ptr] = din;
        x0 = tap_at(t, len, 0);
        x1 = tap_at(t, len, 1);
        if (cfg_mode == vidl_pkg::MODE_LINEAR)
        begin
            y = x0 + (((x1 - x0) * f) >>> FRAC_BITS);
        end
        else
        begin
            xm1 = tap_at(t, len, -1);
            x2  = tap_at(t, len, 2);
            c2  = x1 - xm1;
            v   = x0 - x1;
            w2  = c2 + 2 * v;
            a2  = w2 + 2 * v + (x2 - x0);
            b2  = w2 + a2;
            p   = ((a2 * f) >>> FRAC_BITS) - b2;
            p   = ((p * f) >>> FRAC_BITS) + c2;
            p   = (p * f) >>> FRAC_BITS;
            y   = x0 + (p >>> 1);
        end
        if (y > SAT_HI)
            y = SAT_HI;
        else if (y < SAT_LO)
            y = SAT_LO;
        wr_ptr = (wr_ptr + 1 >= len) ? 0 : wr_ptr + 1;
        span = len <<< FRAC_BITS;
        r = (rd_ptr + longint'(cfg_speed)) % span;
        if (r < 0)
            r += span;
        rd_ptr = r;
        return y[SAMPLE_BITS-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
                sample_mem[i] = '0;
            wr_ptr     = 0;
            rd_ptr     = 0;
            cfg_length = vidl_pkg::RESET_LENGTH;
            cfg_speed  = vidl_pkg::RESET_SPEED;
            cfg_mode   = vidl_pkg::MODE_LINEAR;
            expected_samples.delete();
            n_checked  = 0;
            n_errors   = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    vidl_pkg::REG_LENGTH: cfg_length = cfg_wdata[vidl_pkg::LEN_CFG_W-1:0];
                    vidl_pkg::REG_SPEED:  cfg_speed  = cfg_wdata;
                    vidl_pkg::REG_MODE:   cfg_mode   = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                got = out_data[SAMPLE_BITS-1:0];
                if (expected_samples.size() == 0)
                begin
                    n_errors++;
                    $error("sample_out: unexpected beat, actual %0d", got);
                end
                else
                begin
                    want = expected_samples.pop_front();
                    n_checked++;
                    if (got !== want)
                    begin
                        n_errors++;
                        $error("sample_out mismatch: expected %0d, actual %0d", want, got);
                    end
                end
            end
            if (in_valid && in_ready)
                expected_samples.push_back(interpolate_next(in_data[SAMPLE_BITS-1:0]));
        end
        samples_pending <= expected_samples.size();
        samples_checked <= n_checked;
        mismatch_count  <= n_errors;
    end

endmodule

// ===== dv/testbench.sv =====
module testbench;

    localparam int SBITS          = vidl_pkg::DEF_SAMPLE_BITS;
    localparam int DW             = ((SBITS + 7) / 8) * 8;
    localparam int SPD_W          = vidl_pkg::SPD_W;
    localparam int LEN_W          = vidl_pkg::LEN_CFG_W;
    localparam int PHASES         = 16;
    localparam int PHASE_ITEMS    = 50;
    localparam int SETTLE_CYCLES  = 200;
    localparam int STALL_LIMIT    = 100000;
    localparam logic MODE_HERMITE = 1'b1;
    localparam logic [vidl_pkg::CFG_IDX_W-1:0] REG_SPARE = vidl_pkg::CFG_IDX_W'(3);
    localparam logic [DW-1:0] SAMPLE_MAX = DW'({1'b0, {(SBITS-1){1'b1}}});
    localparam logic [DW-1:0] SAMPLE_MIN = DW'({1'b1, {(SBITS-1){1'b0}}});

    logic                             clk           = 1'b0;
    logic                             rst_n         = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [DW-1:0]                    s_axis_tdata  = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [DW-1:0]                    m_axis_tdata;
    logic                             cfg_we        = 1'b0;
    logic [vidl_pkg::CFG_IDX_W-1:0]   cfg_addr      = '0;
    logic [SPD_W-1:0]                 cfg_wdata     = '0;

    int samples_pending;
    int samples_checked;
    int mismatch_count;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int idle_cycles  = 0;
    int n_sent       = 0;
    int n_settings   = 0;

    logic [LEN_W-1:0] len_sel;
    logic [SPD_W-1:0] spd_sel;

    varispeed_interpolated_delay_line u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    vidl_output_check u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .in_data         (s_axis_tdata),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_data        (m_axis_tdata),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .samples_pending (samples_pending),
        .samples_checked (samples_checked),
        .mismatch_count  (mismatch_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == STALL_LIMIT)
        begin
            $error("no beat for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_sample(input logic [DW-1:0] value);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        n_sent++;
    endtask

    // hold input, wait for every output, then let the pointer update finish
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (samples_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [vidl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [SPD_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [LEN_W-1:0] len, input logic [SPD_W-1:0] spd,
                                  input logic mode);
        drain();
        write_reg(vidl_pkg::REG_LENGTH, SPD_W'(len));
        write_reg(vidl_pkg::REG_SPEED, spd);
        write_reg(vidl_pkg::REG_MODE, SPD_W'(mode));
        write_reg(REG_SPARE, SPD_W'($urandom));
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
    endtask

    function automatic logic [DW-1:0] random_sample();
        case ($urandom_range(9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2, 3:    return DW'(SBITS'($urandom_range(511)) - SBITS'(256));
            default: return DW'($urandom);
        endcase
    endfunction

    initial
    begin
        set_idling(35, 87);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: unit speed, linear, output follows input
        push_sample(SAMPLE_MAX);
        push_sample(SAMPLE_MIN);
        push_sample('0);
        push_sample({DW{1'b1}});
        push_sample(DW'(24'h555555));
        push_sample(DW'(24'hAAAAAA));

        // shortest store, half speed, Hermite overshoot into saturation
        apply_settings(LEN_W'(8), SPD_W'(32'h08000), MODE_HERMITE);
        for (int i = 0; i < 8; i++)
            push_sample(i[0] ? SAMPLE_MIN : SAMPLE_MAX);

        // zero length clamps up, reverse read at four times unit speed
        apply_settings('0, SPD_W'(-262144), vidl_pkg::MODE_LINEAR);
        for (int i = 0; i < 4; i++)
            push_sample(random_sample());

        // length above the store clamps down, largest positive speed
        apply_settings({LEN_W{1'b1}}, SPD_W'(32'h7FFFF), MODE_HERMITE);
        for (int i = 0; i < 3; i++)
            push_sample(random_sample());

        // shrink below the read pointer, most negative speed
        apply_settings(LEN_W'(8), SPD_W'(32'h80000), vidl_pkg::MODE_LINEAR);
        for (int i = 0; i < 4; i++)
            push_sample(random_sample());

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == 6)
                set_idling(87, 35);
            else if (ph == 11)
                set_idling(0, 0);
            case ($urandom_range(9))
                0:       len_sel = LEN_W'($urandom_range(7));
                1:       len_sel = LEN_W'($urandom_range(32769, 65535));
                2:       len_sel = LEN_W'(32768);
                3:       len_sel = LEN_W'(8);
                4:       len_sel = LEN_W'($urandom_range(65, 4096));
                default: len_sel = LEN_W'($urandom_range(8, 64));
            endcase
            case ($urandom_range(7))
                0:       spd_sel = SPD_W'($urandom);
                1:       spd_sel = $urandom_range(1) ? SPD_W'(262144) : SPD_W'(-262144);
                2:       spd_sel = '0;
                default: spd_sel = SPD_W'($urandom_range(524288) - 262144);
            endcase
            apply_settings(len_sel, spd_sel, 1'($urandom_range(1)));
            for (int i = 0; i < PHASE_ITEMS; i++)
                push_sample(random_sample());
        end

        drain();
        if (samples_pending != 0)
            $error("%0d expected samples never appeared", samples_pending);
        $display("Sent %0d samples and checked %0d outputs over %0d register settings:",
                 n_sent, samples_checked, n_settings);
        $display("linear and Hermite reads, clamped lengths, speeds across the full 20-bit range.");
        if (mismatch_count == 0 && samples_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
